### sv/mmbd_pkg.sv
`default_nettype none
package mmbd_pkg;

  localparam int LANE_W = 10;
  localparam int SUM_W  = 4 * LANE_W;
  localparam int CNT_W  = 13;
  localparam int LVL_W  = 4;
  localparam int COORD_W = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic read;
    logic calc;
    logic advance;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic more;
    logic has_levels;
  } status_t;

endpackage
`default_nettype wire

### sv/mipmap_box_downsampler.sv
// Latency: after the input transaction the result is valid once the line buffer read
// and compute states have passed; each further level adds output transaction, read, compute.
// Throughput: no new pixel is taken until every level it completes has been emitted (a
// 1x1 image has no levels), and output stalls hold the input too; this is set by the
// single shared level datapath, which serves one level at a time.
// Synchronous reset clears counters and pair sums; line buffer is not cleared.
`default_nettype none
module mipmap_box_downsampler #(
  parameter int MAX_LEVELS = 13,
  parameter int MAX_SIZE   = 4096
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [12:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  red,
  input  wire  [7:0]  green,
  input  wire  [7:0]  blue,
  input  wire  [7:0]  alpha,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  level,
  output logic [10:0] col,
  output logic [10:0] row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        last
);

  mmbd_pkg::cmd_t    cmd;
  mmbd_pkg::status_t sts;

  mmbd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .sts(sts), .cmd(cmd)
  );

  mmbd_dp #(.MAX_LEVELS(MAX_LEVELS), .MAX_SIZE(MAX_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .level(level), .col(col), .row(row),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha), .last(last)
  );

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level != 4'd0) else $error("level zero emitted");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !out_valid) else $error("config while busy");
`endif

endmodule
`default_nettype wire

### sv/mmbd_ctrl.sv
`default_nettype none
module mmbd_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire                    out_ready,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  mmbd_pkg::status_t sts,
  output mmbd_pkg::cmd_t         cmd
);

  mmbd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cfg_ready = (state == mmbd_pkg::ST_IDLE);
    cmd.restart = cfg_valid && cfg_ready;
    unique case (state)
      mmbd_pkg::ST_IDLE: begin
        in_ready = !cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.start = 1'b1;
          if (sts.has_levels) state_next = mmbd_pkg::ST_READ;
        end
      end
      mmbd_pkg::ST_READ: begin
        cmd.read = 1'b1;
        state_next = mmbd_pkg::ST_CALC;
      end
      mmbd_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
        if (sts.emit) state_next = mmbd_pkg::ST_OUT;
        else state_next = mmbd_pkg::ST_IDLE;
      end
      mmbd_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next = sts.more ? mmbd_pkg::ST_READ : mmbd_pkg::ST_IDLE;
        end
      end
      default: state_next = mmbd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/mmbd_dp.sv
`default_nettype none
module mmbd_dp #(
  parameter int MAX_LEVELS = 13,
  parameter int MAX_SIZE   = 4096
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  mmbd_pkg::cmd_t          cmd,
  output mmbd_pkg::status_t             sts,
  input  wire  [0:0]                    cfg_index,
  input  wire  [mmbd_pkg::CNT_W-1:0]    cfg_data,
  input  wire  [7:0]                    red,
  input  wire  [7:0]                    green,
  input  wire  [7:0]                    blue,
  input  wire  [7:0]                    alpha,
  output logic [mmbd_pkg::LVL_W-1:0]    level,
  output logic [mmbd_pkg::COORD_W-1:0]  col,
  output logic [mmbd_pkg::COORD_W-1:0]  row,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha,
  output logic                          last
);

  localparam int LW = mmbd_pkg::LANE_W;
  localparam int SW = mmbd_pkg::SUM_W;
  localparam int CW = mmbd_pkg::CNT_W;
  localparam int LIW = $clog2(MAX_LEVELS);
  localparam int AW = $clog2(MAX_SIZE);
  localparam int DW = $clog2(MAX_SIZE + 1);

  logic [CW-1:0] base_width, base_height;
  logic [SW-1:0] pend [MAX_LEVELS];
  logic [CW-1:0] xcnt [MAX_LEVELS];
  logic [CW-1:0] ycnt [MAX_LEVELS];
  logic [SW-1:0] line_mem [MAX_SIZE];

  logic [LIW-1:0] lvl_idx;
  logic [DW-1:0]  w, h;
  logic [AW-1:0]  off;
  logic [SW-1:0]  pix;
  logic [SW-1:0]  line_rd;
  logic [LIW-1:0] num_levels;

  logic [DW-1:0] cw_dim, ch_dim, m_dim;
  logic [CW-1:0] x, y, x_inc, y_inc;
  logic [DW-1:0] w2, h2, bx, by;
  logic          hdone, emit;
  logic [SW-1:0] pair, total, avg;
  logic [AW-1:0] idx;

  logic [LIW-1:0] nlvl;
  logic [CW-1:0]  nx, ny;
  logic [DW-1:0]  w4, h4, nbx, nby;
  logic           next_emit;

  function automatic logic [DW-1:0] clamp_dim(input logic [CW-1:0] v);
    if (v == '0) return DW'(1);
    if ({19'd0, v} > 32'(MAX_SIZE)) return DW'(MAX_SIZE);
    return DW'(v);
  endfunction

  always_comb begin
    cw_dim = clamp_dim(base_width);
    ch_dim = clamp_dim(base_height);
    m_dim = (cw_dim > ch_dim) ? cw_dim : ch_dim;
    num_levels = '0;
    for (int i = DW - 1; i >= 1; i--) begin
      if (num_levels == '0 && m_dim[i]) num_levels = LIW'(i);
    end
    if (32'(num_levels) > MAX_LEVELS - 1) num_levels = LIW'(MAX_LEVELS - 1);
  end

  assign sts.has_levels = (num_levels != '0);

  always_comb begin
    x = xcnt[lvl_idx];
    y = ycnt[lvl_idx];
    w2 = (w[DW-1:1] == '0) ? DW'(1) : DW'(w >> 1);
    h2 = (h[DW-1:1] == '0) ? DW'(1) : DW'(h >> 1);
    bx = (w == DW'(1)) ? '0 : DW'(x >> 1);
    by = (h == DW'(1)) ? '0 : DW'(y >> 1);
    idx = AW'(off + AW'(bx));
    hdone = (w == DW'(1)) || x[0];
    pair = (w == DW'(1)) ? (pix << 1) : (pend[lvl_idx] + pix);
    emit = 1'b0;
    total = '0;
    if (hdone && bx < w2 && by < h2) begin
      if (h == DW'(1)) begin
        total = pair << 1;
        emit = 1'b1;
      end else if (y[0]) begin
        total = line_rd + pair;
        emit = 1'b1;
      end
    end
    for (int c = 0; c < 4; c++) begin
      avg[c*LW +: LW] = LW'(total[c*LW+2 +: 8]);
    end
    x_inc = x + CW'(1);
    y_inc = y;
    if ({{(32-CW){1'b0}}, x_inc} >= 32'(w)) begin
      x_inc = '0;
      y_inc = y + CW'(1);
      if ({{(32-CW){1'b0}}, y_inc} >= 32'(h)) y_inc = '0;
    end
  end

  // whether the next level completes a block on this pixel; only counters and sizes decide
  always_comb begin
    nlvl = sts.more ? LIW'(lvl_idx + LIW'(1)) : lvl_idx;
    nx = xcnt[nlvl];
    ny = ycnt[nlvl];
    w4 = (w2[DW-1:1] == '0) ? DW'(1) : DW'(w2 >> 1);
    h4 = (h2[DW-1:1] == '0) ? DW'(1) : DW'(h2 >> 1);
    nbx = (w2 == DW'(1)) ? '0 : DW'(nx >> 1);
    nby = (h2 == DW'(1)) ? '0 : DW'(ny >> 1);
    next_emit = ((w2 == DW'(1)) || nx[0]) && nbx < w4 && nby < h4 &&
                ((h2 == DW'(1)) || ny[0]);
  end

  assign sts.emit = emit;
  assign sts.more = (lvl_idx != num_levels - LIW'(1));

  always_ff @(posedge clk) begin
    if (cmd.read) line_rd <= line_mem[idx];
    if (cmd.calc && hdone && bx < w2 && by < h2 && h != DW'(1) && !y[0])
      line_mem[idx] <= pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_width <= CW'(1);
      base_height <= CW'(1);
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pend[i] <= '0;
        xcnt[i] <= '0;
        ycnt[i] <= '0;
      end
    end else begin
      if (cmd.restart) begin
        if (cfg_index == 1'b0) base_width <= cfg_data;
        else base_height <= cfg_data;
        for (int i = 0; i < MAX_LEVELS; i++) begin
          pend[i] <= '0;
          xcnt[i] <= '0;
          ycnt[i] <= '0;
        end
      end
      if (cmd.calc) begin
        if (w != DW'(1) && !x[0]) pend[lvl_idx] <= pix;
        xcnt[lvl_idx] <= x_inc;
        ycnt[lvl_idx] <= y_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lvl_idx <= '0;
      w <= cw_dim;
      h <= ch_dim;
      off <= '0;
      pix <= {2'b00, alpha, 2'b00, blue, 2'b00, green, 2'b00, red};
    end
    if (cmd.calc) begin
      level <= mmbd_pkg::LVL_W'(lvl_idx + LIW'(1));
      col <= mmbd_pkg::COORD_W'(bx);
      row <= mmbd_pkg::COORD_W'(by);
      out_red <= total[2 +: 8];
      out_green <= total[LW+2 +: 8];
      out_blue <= total[2*LW+2 +: 8];
      out_alpha <= total[3*LW+2 +: 8];
      pix <= avg;
    end
    if (cmd.calc) last <= !(sts.more && next_emit);
    if (cmd.advance) begin
      lvl_idx <= lvl_idx + LIW'(1);
      off <= AW'(off + AW'(w2));
      w <= w2;
      h <= h2;
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;

  typedef enum logic [0:0] {REG_WIDTH, REG_HEIGHT} reg_idx_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [10:0] col;
    logic [10:0] row;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } mip_pix_t;

  typedef struct {
    logic [7:0] r, g, b, a;
    bit         known;
    mip_pix_t   known_pix;
  } stim_row_t;

  localparam int NLVL    = 13;
  localparam int LINE_SZ = 4096;
  localparam int SETTLE  = 60;
  localparam int LIMIT   = 600000;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid, in_ready;
  logic [7:0]  red, green, blue, alpha;
  logic        out_valid, out_ready;
  logic [3:0]  level;
  logic [10:0] col, row;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        last;

  mipmap_box_downsampler DUT (.*);

  logic [12:0] width_reg, height_reg;
  logic [39:0] line_sums [LINE_SZ];
  logic [39:0] pend_sum [NLVL];
  int unsigned col_cnt [NLVL];
  int unsigned row_cnt [NLVL];

  mip_pix_t expected_mips[$];
  mip_pix_t step_mips[$];
  int errors, n_pix, n_mips, n_images, cycles;
  int rx_wait, long_hold;
  bit no_idle;
  bit want_hold;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [12:0] v);
    if (v == 0) return 1;
    if (v > LINE_SZ) return LINE_SZ;
    return v;
  endfunction

  function automatic int unsigned half_of(int unsigned v);
    return (v / 2 < 1) ? 1 : v / 2;
  endfunction

  function automatic void restart_image();
    for (int i = 0; i < NLVL; i++) begin
      pend_sum[i] = '0;
      col_cnt[i] = 0;
      row_cnt[i] = 0;
    end
  endfunction

  // one base pixel through the whole chain; results land in step_mips
  function automatic void mip_predict(logic [7:0] r, g, b, a);
    int unsigned w, h, m, nlev, off, s, x, y, bx, by, w2, h2;
    logic [39:0] pix, pair, total, avg;
    bit hdone, emit;
    mip_pix_t e;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    m = (w > h) ? w : h;
    nlev = 0;
    off = 0;
    while (m > 1) begin
      m >>= 1;
      nlev++;
    end
    if (nlev > NLVL - 1) nlev = NLVL - 1;
    pix = {2'b0, a, 2'b0, b, 2'b0, g, 2'b0, r};
    step_mips.delete();
    for (int unsigned lv = 1; lv <= nlev; lv++) begin
      s = lv - 1;
      w2 = half_of(w);
      h2 = half_of(h);
      x = col_cnt[s];
      y = row_cnt[s];
      bx = (w == 1) ? 0 : x >> 1;
      by = (h == 1) ? 0 : y >> 1;
      pair = '0;
      total = '0;
      hdone = 0;
      emit = 0;
      if (w == 1) begin
        pair = pix << 1;
        hdone = 1;
      end else if (!x[0]) begin
        pend_sum[s] = pix;
      end else begin
        pair = pend_sum[s] + pix;
        hdone = 1;
      end
      if (hdone && bx < w2 && by < h2) begin
        if (h == 1) begin
          total = pair << 1;
          emit = 1;
        end else if (!y[0]) begin
          line_sums[(off + bx) % LINE_SZ] = pair;
        end else begin
          total = line_sums[(off + bx) % LINE_SZ] + pair;
          emit = 1;
        end
      end
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col_cnt[s] = x;
      row_cnt[s] = y;
      if (!emit) break;
      avg = '0;
      for (int c = 0; c < 4; c++) avg[10*c +: 10] = {2'b0, total[10*c+2 +: 8]};
      e.level = 4'(lv);
      e.col = 11'(bx);
      e.row = 11'(by);
      e.r = avg[7:0];
      e.g = avg[17:10];
      e.b = avg[27:20];
      e.a = avg[37:30];
      e.last = 0;
      step_mips.push_back(e);
      pix = avg;
      off += w2;
      w = w2;
      h = h2;
    end
    if (step_mips.size() > 0) step_mips[step_mips.size()-1].last = 1;
  endfunction

  // receiver: per-transaction stall plus one long hold-off
  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_ready <= 0;
      long_hold <= long_hold - 1;
    end else if (rx_wait > 0) begin
      out_ready <= 0;
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    mip_pix_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {level, col, row, out_red, out_green, out_blue, out_alpha, last};
      n_mips++;
      rx_wait <= no_idle ? 0 : $urandom_range(0, 12);
      if (expected_mips.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_mips.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
    restart_image();
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic push_pixel(stim_row_t sr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    red <= sr.r;
    green <= sr.g;
    blue <= sr.b;
    alpha <= sr.a;
    do @(posedge clk); while (!in_ready);
    n_pix++;
    mip_predict(sr.r, sr.g, sr.b, sr.a);
    if (sr.known) begin
      if (step_mips.size() > 0) expected_mips.push_back(sr.known_pix);
    end else begin
      foreach (step_mips[i]) expected_mips.push_back(step_mips[i]);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (expected_mips.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_image(logic [12:0] w, logic [12:0] h, int npix, bit extremes);
    stim_row_t sr;
    drain();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    n_images++;
    if (want_hold) begin
      long_hold = 400;
      want_hold = 0;
    end
    for (int i = 0; i < npix; i++) begin
      sr.known = 0;
      if (extremes) begin
        sr.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        sr.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        sr.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        sr.a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        {sr.r, sr.g, sr.b, sr.a} = $urandom;
      end
      push_pixel(sr);
    end
  endtask

  stim_row_t dir_tab[16];

  initial begin
    int w, h, np, done;
    rst = 1;
    cfg_valid = 0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_valid = 0;
    red = 0;
    green = 0;
    blue = 0;
    alpha = 0;
    out_ready = 0;
    rx_wait = 0;
    long_hold = 0;
    no_idle = 0;
    want_hold = 0;
    errors = 0;
    n_pix = 0;
    n_mips = 0;
    n_images = 0;
    cycles = 0;
    width_reg = 1;
    height_reg = 1;
    restart_image();
    for (int i = 0; i < 16; i++) begin
      {dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].a} = 32'hFFFF_FFFF;
      dir_tab[i].known = 0;
      dir_tab[i].known_pix = '0;
    end
    for (int i = 4; i < 8; i++) {dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].a} = '0;
    dir_tab[11].a = 8'hFE;
    for (int i = 12; i < 16; i++)
      {dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].a} =
        (i % 2) ? 32'h55AA_55AA : 32'hAA55_AA55;
    dir_tab[3].known = 1;
    dir_tab[3].known_pix = {4'd1, 11'd0, 11'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
    dir_tab[7].known = 1;
    dir_tab[7].known_pix = {4'd1, 11'd0, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
    dir_tab[11].known = 1;
    dir_tab[11].known_pix = {4'd1, 11'd0, 11'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b1};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // 1x1 after reset: no levels
    for (int i = 0; i < 2; i++) push_pixel(dir_tab[i]);
    drain();
    cfg_write(REG_WIDTH, 13'd2);
    cfg_write(REG_HEIGHT, 13'd2);
    for (int i = 0; i < 16; i++) push_pixel(dir_tab[i]);
    run_image(13'd1, 13'd4, 4, 1);
    run_image(13'd4, 13'd1, 4, 1);
    run_image(13'd3, 13'd3, 9, 1);
    run_image(13'd0, 13'd0, 2, 1);
    run_image(13'h1FFF, 13'd1, 8, 1);
    run_image(13'd1, 13'h1FFF, 8, 1);

    done = 0;
    while (done < 370) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 8191);
          np = $urandom_range(1, 12);
        end
        1: begin
          w = $urandom_range(16, 32);
          h = $urandom_range(2, 4);
          np = w * h;
        end
        default: begin
          w = $urandom_range(1, 9);
          h = $urandom_range(1, 9);
          np = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h) : w * h;
        end
      endcase
      // long receiver hold-off on a full 8x8 image so the block backs up
      if (n_images == 12) begin
        w = 8;
        h = 8;
        np = 64;
        want_hold = 1;
      end
      run_image(13'(w), 13'(h), np, 0);
      done += np;
    end
    no_idle = 0;
    drain();

    $display("%0d images, %0d pixels sent, %0d mip pixels checked, %0d errors",
             n_images, n_pix, n_mips, errors);
    $display("covered odd sizes, unit dimensions, out-of-range sizes and aborted images");
    if (errors == 0 && expected_mips.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
